// File: sv/ecg_pkg.sv
package ecg_pkg;

   // fixed-point formats
   localparam int FRAC_BITS = 48;
   localparam int LEN_GUARD = 23;
   localparam int E2_SHIFT  = FRAC_BITS - 40;
   localparam int IDX_W     = $clog2(FRAC_BITS);

   // divide / square root step counts
   localparam int DIV_STEPS  = 62;
   localparam int SQRT_STEPS = (64 + FRAC_BITS) / 2;
   localparam int STEP_W     = $clog2((DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS);

   localparam int CSR_ADDR_W = 5;

   localparam logic [63:0]        PI_Q60          = 64'h3243F6A8885A308D;
   localparam logic signed [63:0] TWO_OVER_PI_Q63 = 64'sh517CC1B727220A95;
   localparam logic signed [63:0] QCAP            = 64'sh3FFFFFFFFFFFFFFF;
   localparam logic signed [63:0] INT64_MAX       = 64'sh7FFFFFFFFFFFFFFF;
   localparam logic signed [63:0] ONE_Q           = 64'sh1 << FRAC_BITS;
   localparam logic signed [63:0] PI_Q            = signed'(PI_Q60 >> (60 - FRAC_BITS));
   localparam logic signed [63:0] CONV_THR        =
      (FRAC_BITS >= 45) ? (64'sh1 << (FRAC_BITS - 44)) : 64'sd2;
   localparam logic signed [31:0] LAT_POLE        = 32'sh40000000;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_POLE  = 2'd1;
   localparam logic [1:0] STAT_LIMIT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SEMI_MAJOR = 2'd0;
   localparam logic [1:0] CSR_ECC_SQ     = 2'd1;
   localparam logic [1:0] CSR_ITER_LIMIT = 2'd2;

   // unit mode bits
   localparam logic CORDIC_VECTOR = 1'b1;
   localparam logic CORDIC_ROTATE = 1'b0;
   localparam logic MUL_SHIFT_ANG = 1'b1;
   localparam logic MUL_SHIFT_FRC = 1'b0;
   localparam logic FIT_SQRT      = 1'b1;
   localparam logic FIT_DIV       = 1'b0;

   typedef struct packed {
      logic start;
      logic mode;
   } unit_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_VXY, ST_RHO, ST_LON, ST_VRZ, ST_ROT, ST_SS, ST_ES, ST_SQ, ST_ND,
      ST_EN, ST_ENS, ST_VB1, ST_CHK, ST_FROT, ST_FDIV, ST_LAT, ST_PSQ, ST_PMUL, ST_DONE
   } state_type;

   typedef logic signed [63:0] atan_rom_type [FRAC_BITS];

   // shift-subtract division, elaboration only
   function automatic logic [127:0] udiv_const(input logic [127:0] n, input logic [127:0] d);
      logic [127:0] q;
      logic [127:0] r;
      q = '0;
      r = '0;
      for (int b = 127; b >= 0; b--) begin
         r = {r[126:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // arctangent of 2^-i from the alternating series in 2^-62 units
   function automatic atan_rom_type build_atan();
      atan_rom_type rom;
      logic [63:0]  sum;
      logic [127:0] term;
      int           e;
      rom[0] = signed'(PI_Q60 >> (62 - FRAC_BITS));
      for (int i = 1; i < FRAC_BITS; i++) begin
         sum = '0;
         for (int k = 0; k < 63; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
               term = udiv_const(128'(64'h1 << e), 128'(2 * k + 1));
               if (k % 2 == 1) sum = sum - term[63:0];
               else sum = sum + term[63:0];
            end
         end
         rom[i] = signed'((sum + (64'h1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
      end
      return rom;
   endfunction

   // reciprocal of the cordic gain
   function automatic logic signed [63:0] build_inv_gain();
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic [127:0]       q;
      x = ONE_Q;
      y = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x = x - ys;
            y = y + xs;
         end else begin
            x = x + ys;
            y = y - xs;
         end
      end
      q = udiv_const(128'h1 << (2 * FRAC_BITS), 128'(x));
      if (q > 128'(QCAP)) q = 128'(QCAP);
      return signed'(q[63:0]);
   endfunction

   localparam atan_rom_type       ATAN_ROM = build_atan();
   localparam logic signed [63:0] INV_GAIN = build_inv_gain();

endpackage

// File: sv/ecg_req_if.sv
interface ecg_req_if;
   logic               valid;
   logic               ready;
   logic signed [36:0] pos_x_mm;
   logic signed [36:0] pos_y_mm;
   logic signed [36:0] pos_z_mm;

   modport source (output valid, output pos_x_mm, output pos_y_mm, output pos_z_mm,
                   input ready);
   modport sink (input valid, input pos_x_mm, input pos_y_mm, input pos_z_mm,
                 output ready);
endinterface

// File: sv/ecg_rsp_if.sv
interface ecg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] latitude;
   logic signed [31:0] longitude;
   logic signed [36:0] height_mm;
   logic [1:0]         status;

   modport source (output valid, output latitude, output longitude, output height_mm,
                   output status, input ready);
   modport sink (input valid, input latitude, input longitude, input height_mm,
                 input status, output ready);
endinterface

// File: sv/ecg_cordic.sv
module ecg_cordic import ecg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  unit_cmd_type       cmd,
   input  logic signed [63:0] x_init,
   input  logic signed [63:0] y_init,
   input  logic signed [63:0] z_init,
   output logic               done,
   output logic signed [63:0] x_out,
   output logic signed [63:0] y_out,
   output logic signed [63:0] z_out
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAC_BITS - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               vec_ff, vec_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [63:0] x_ff, x_in;
   logic signed [63:0] y_ff, y_in;
   logic signed [63:0] z_ff, z_in;
   logic signed [63:0] xs, ys;
   logic               ccw;

   always_comb begin
      xs  = x_ff >>> idx_ff;
      ys  = y_ff >>> idx_ff;
      // vectoring drives y to zero, rotation drives the angle to zero
      ccw = vec_ff ? y_ff[63] : !z_ff[63];

      busy_in = busy_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         vec_in  = cmd.mode;
         idx_in  = '0;
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
      end else if (busy_ff) begin
         if (ccw) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ATAN_ROM[idx_ff];
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ATAN_ROM[idx_ff];
         end
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// File: sv/ecg_mul.sv
module ecg_mul import ecg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  unit_cmd_type       cmd,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] p
);

   localparam logic [2:0] LAST_PART = 3'd4;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [2:0]         k_ff, k_in;
   logic [63:0]        ua_ff, ua_in;
   logic [63:0]        ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic               long_ff, long_in;
   logic [127:0]       acc_ff, acc_in;
   logic signed [63:0] p_ff, p_in;
   logic [31:0]        ha, hb;
   logic [63:0]        pp;
   logic [127:0]       ppw;
   logic [127:0]       scaled;
   logic signed [63:0] mag;

   always_comb begin
      ha  = k_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      hb  = k_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp  = 64'(ha) * 64'(hb);
      case (k_ff[1:0])
         2'd0:    ppw = {64'b0, pp};
         2'd3:    ppw = {pp, 64'b0};
         default: ppw = {32'b0, pp, 32'b0};
      endcase
      scaled = long_ff ? (acc_ff >> (FRAC_BITS + 33)) : (acc_ff >> FRAC_BITS);
      mag    = (|scaled[127:63]) ? INT64_MAX : signed'({1'b0, scaled[62:0]});

      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      long_in = long_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         k_in    = '0;
         ua_in   = a[63] ? 64'(0) - a : a;
         ub_in   = b[63] ? 64'(0) - b : b;
         neg_in  = a[63] ^ b[63];
         long_in = cmd.mode;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (k_ff == LAST_PART) begin
            p_in    = neg_ff ? -mag : mag;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = acc_ff + ppw;
            k_in   = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      long_ff <= long_in;
      acc_ff  <= acc_in;
      p_ff    <= p_in;
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule

// File: sv/ecg_fit.sv
module ecg_fit import ecg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  unit_cmd_type       cmd,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic signed [63:0] quo
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              sqrt_ff, sqrt_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [63:0]       rem_ff, rem_in;
   logic [63:0]       q_ff, q_in;
   logic [127:0]      nsh_ff, nsh_in;
   logic [63:0]       den_ff, den_in;
   logic [127:0]      wide_num;
   logic [127:0]      head;
   logic [64:0]       a_op, b_op, diff;
   logic              ge;

   always_comb begin
      wide_num = {64'b0, num} << FRAC_BITS;
      head     = wide_num >> DIV_STEPS;
      // one restoring step: one quotient bit, or one root bit from two dividend bits
      a_op = sqrt_ff ? {1'b0, rem_ff[61:0], nsh_ff[127:126]} : {rem_ff, nsh_ff[127]};
      b_op = sqrt_ff ? {1'b0, q_ff[61:0], 2'b01} : {1'b0, den_ff};
      ge   = a_op >= b_op;
      diff = a_op - b_op;

      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      nsh_in  = nsh_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         sqrt_in = cmd.mode;
         q_in    = '0;
         rem_in  = '0;
         den_in  = den;
         if (cmd.mode == FIT_SQRT) begin
            if (num <= 0) begin
               done_in = 1'b1;
            end else begin
               busy_in = 1'b1;
               nsh_in  = wide_num << (128 - 2 * SQRT_STEPS);
               cnt_in  = STEP_W'(SQRT_STEPS - 1);
            end
         end else if (den <= 0 || num < 0 || head >= {64'b0, den}) begin
            // quotient would not fit: cap
            q_in    = QCAP;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            rem_in  = head[63:0];
            nsh_in  = wide_num << (128 - DIV_STEPS);
            cnt_in  = STEP_W'(DIV_STEPS - 1);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : a_op[63:0];
         q_in   = {q_ff[62:0], ge};
         nsh_in = sqrt_ff ? (nsh_ff << 2) : (nsh_ff << 1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      nsh_ff  <= nsh_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = signed'(q_ff);

endmodule

// File: sv/ecef_to_geodetic.sv
// work: each latitude refinement uses the 48-step cordic unit and the
//   62-step divide unit; the pole path needs only a square root and a product
// throughput: one word at a time; the next word is taken once the result is in
//   the output register, which a stalled consumer holds while the next word runs
// reset: synchronous, active high; registers return to the WGS84 defaults
module ecef_to_geodetic import ecg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ecg_req_if.sink               req_chan,
   ecg_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   // configuration registers
   logic [32:0] semi_major_ff;
   logic [36:0] ecc_sq_ff;
   logic [6:0]  iter_limit_ff;
   logic        csr_write;

   // sequencer
   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   // working registers, lengths in mm * 2^23, angles and fractions in 2^-48
   logic signed [63:0] x_ff, x_in;
   logic signed [63:0] y_ff, y_in;
   logic signed [63:0] z_ff, z_in;
   logic signed [63:0] ang_ff, ang_in;
   logic signed [63:0] rho_ff, rho_in;
   logic signed [63:0] b0_ff, b0_in;
   logic signed [63:0] b1_ff, b1_in;
   logic signed [63:0] s_ff, s_in;
   logic signed [63:0] n_ff, n_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [63:0] h_ff, h_in;
   logic signed [31:0] lat_ff, lat_in;
   logic signed [31:0] lon_ff, lon_in;
   logic [7:0]         count_ff, count_in;
   logic [1:0]         status_ff, status_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] lat_out_ff, lat_out_in;
   logic signed [31:0] lon_out_ff, lon_out_in;
   logic signed [36:0] hgt_out_ff, hgt_out_in;
   logic [1:0]         stat_out_ff, stat_out_in;

   // shared units
   unit_cmd_type       cor_cmd, mul_cmd, fit_cmd;
   logic signed [63:0] cor_x0, cor_y0, cor_z0;
   logic               cor_done;
   logic signed [63:0] cor_x, cor_y, cor_z;
   logic signed [63:0] mul_a, mul_b, mul_p;
   logic               mul_done;
   logic signed [63:0] fit_num, fit_den, fit_quo;
   logic               fit_done;

   // helpers
   logic signed [63:0] semi_major_q, ecc_sq_q;
   logic signed [63:0] in_x, in_y, in_z;
   logic signed [63:0] diff, abs_diff, abs_z;
   logic signed [63:0] h_round, h_mm;
   logic [7:0]         count_next;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_major_ff <= 33'd6378137000;
         ecc_sq_ff     <= 37'd7360548600;
         iter_limit_ff <= 7'd100;
      end else if (csr_write) begin
         unique case (paddr[4:3])
            CSR_SEMI_MAJOR: semi_major_ff <= pwdata[32:0];
            CSR_ECC_SQ:     ecc_sq_ff     <= pwdata[36:0];
            CSR_ITER_LIMIT: iter_limit_ff <= pwdata[6:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         CSR_SEMI_MAJOR: prdata = 64'(semi_major_ff);
         CSR_ECC_SQ:     prdata = 64'(ecc_sq_ff);
         CSR_ITER_LIMIT: prdata = 64'(iter_limit_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- units
   ecg_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cor_cmd),
      .x_init (cor_x0),
      .y_init (cor_y0),
      .z_init (cor_z0),
      .done   (cor_done),
      .x_out  (cor_x),
      .y_out  (cor_y),
      .z_out  (cor_z)
   );

   ecg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   ecg_fit u_fit (
      .clock (clock),
      .reset (reset),
      .cmd   (fit_cmd),
      .num   (fit_num),
      .den   (fit_den),
      .done  (fit_done),
      .quo   (fit_quo)
   );

   // ---------------------------------------------------------------- datapath helpers
   assign semi_major_q = 64'(semi_major_ff) << LEN_GUARD;
   assign ecc_sq_q     = 64'(ecc_sq_ff) << E2_SHIFT;
   assign in_x         = 64'(req_chan.pos_x_mm) <<< LEN_GUARD;
   assign in_y         = 64'(req_chan.pos_y_mm) <<< LEN_GUARD;
   assign in_z         = 64'(req_chan.pos_z_mm) <<< LEN_GUARD;
   assign diff         = b1_ff - b0_ff;
   assign abs_diff     = diff[63] ? -diff : diff;
   assign abs_z        = z_ff[63] ? -z_ff : z_ff;
   assign count_next   = count_ff + 8'd1;
   // round height to mm
   assign h_round      = h_ff + (64'sh1 << (LEN_GUARD - 1));
   assign h_mm         = h_round >>> LEN_GUARD;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      ang_in       = ang_ff;
      rho_in       = rho_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      s_in         = s_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      h_in         = h_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      lat_out_in   = lat_out_ff;
      lon_out_in   = lon_out_ff;
      hgt_out_in   = hgt_out_ff;
      stat_out_in  = stat_out_ff;

      cor_cmd = '0;
      mul_cmd = '0;
      fit_cmd = '0;
      cor_x0  = rho_ff;
      cor_y0  = z_ff;
      cor_z0  = '0;
      mul_a   = t_ff;
      mul_b   = s_ff;
      fit_num = semi_major_q;
      fit_den = t_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               x_in      = in_x;
               y_in      = in_y;
               z_in      = in_z;
               count_in  = '0;
               status_in = STAT_OK;
               if (in_x == 0 && in_y == 0) begin
                  // pole: latitude fixed, only the height needs work
                  lat_in    = (in_z > 0) ? LAT_POLE : -LAT_POLE;
                  lon_in    = '0;
                  status_in = STAT_POLE;
                  state_in  = ST_PSQ;
               end else begin
                  // left half plane: fold by pi so the cordic converges
                  if (in_x < 0) begin
                     ang_in = (in_y < 0) ? -PI_Q : PI_Q;
                     x_in   = -in_x;
                     y_in   = -in_y;
                  end else begin
                     ang_in = '0;
                  end
                  state_in = ST_VXY;
               end
            end
         end
         ST_VXY: begin
            // magnitude and longitude of (x, y)
            cor_cmd = '{start: !pend_ff, mode: CORDIC_VECTOR};
            cor_x0  = x_ff;
            cor_y0  = y_ff;
            cor_z0  = ang_ff;
            if (cor_done) begin
               t_in     = cor_x;
               ang_in   = cor_z;
               state_in = ST_RHO;
            end
         end
         ST_RHO: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_FRC};
            mul_b   = INV_GAIN;
            if (mul_done) begin
               rho_in   = mul_p;
               state_in = ST_LON;
            end
         end
         ST_LON: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_ANG};
            mul_a   = ang_ff;
            mul_b   = TWO_OVER_PI_Q63;
            if (mul_done) begin
               lon_in   = mul_p[31:0];
               state_in = ST_VRZ;
            end
         end
         ST_VRZ: begin
            // first latitude guess atan2(z, rho)
            cor_cmd = '{start: !pend_ff, mode: CORDIC_VECTOR};
            if (cor_done) begin
               b0_in    = cor_z;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cor_cmd = '{start: !pend_ff, mode: CORDIC_ROTATE};
            cor_x0  = INV_GAIN;
            cor_y0  = '0;
            cor_z0  = b0_ff;
            if (cor_done) begin
               s_in     = cor_y;
               state_in = ST_SS;
            end
         end
         ST_SS: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_FRC};
            mul_a   = s_ff;
            if (mul_done) begin
               t_in     = mul_p;
               state_in = ST_ES;
            end
         end
         ST_ES: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_FRC};
            mul_a   = ecc_sq_q;
            mul_b   = t_ff;
            if (mul_done) begin
               t_in     = mul_p;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            fit_cmd = '{start: !pend_ff, mode: FIT_SQRT};
            fit_num = ONE_Q - t_ff;
            if (fit_done) begin
               t_in     = fit_quo;
               state_in = ST_ND;
            end
         end
         ST_ND: begin
            // prime vertical radius
            fit_cmd = '{start: !pend_ff, mode: FIT_DIV};
            if (fit_done) begin
               n_in     = fit_quo;
               state_in = ST_EN;
            end
         end
         ST_EN: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_FRC};
            mul_a   = ecc_sq_q;
            mul_b   = n_ff;
            if (mul_done) begin
               t_in     = mul_p;
               state_in = ST_ENS;
            end
         end
         ST_ENS: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_FRC};
            if (mul_done) begin
               t_in     = mul_p;
               state_in = ST_VB1;
            end
         end
         ST_VB1: begin
            cor_cmd = '{start: !pend_ff, mode: CORDIC_VECTOR};
            cor_y0  = z_ff + t_ff;
            if (cor_done) begin
               b1_in    = cor_z;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (abs_diff < CONV_THR) begin
               state_in = ST_FROT;
            end else begin
               b0_in    = b1_ff;
               count_in = count_next;
               if (count_next > {1'b0, iter_limit_ff}) begin
                  status_in = STAT_LIMIT;
                  state_in  = ST_FROT;
               end else begin
                  state_in = ST_ROT;
               end
            end
         end
         ST_FROT: begin
            cor_cmd = '{start: !pend_ff, mode: CORDIC_ROTATE};
            cor_x0  = INV_GAIN;
            cor_y0  = '0;
            cor_z0  = b1_ff;
            if (cor_done) begin
               // cosine under one unit is clamped so the height saturates
               t_in     = (cor_x < 1) ? 64'sd1 : cor_x;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            fit_cmd = '{start: !pend_ff, mode: FIT_DIV};
            fit_num = rho_ff;
            if (fit_done) begin
               h_in     = fit_quo - n_ff;
               state_in = ST_LAT;
            end
         end
         ST_LAT: begin
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_ANG};
            mul_a   = b1_ff;
            mul_b   = TWO_OVER_PI_Q63;
            if (mul_done) begin
               lat_in   = mul_p[31:0];
               state_in = ST_DONE;
            end
         end
         ST_PSQ: begin
            fit_cmd = '{start: !pend_ff, mode: FIT_SQRT};
            fit_num = ONE_Q - ecc_sq_q;
            if (fit_done) begin
               t_in     = fit_quo;
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            // polar radius a * sqrt(1 - e2)
            mul_cmd = '{start: !pend_ff, mode: MUL_SHIFT_FRC};
            mul_a   = semi_major_q;
            mul_b   = t_ff;
            if (mul_done) begin
               h_in     = abs_z - mul_p;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               lat_out_in   = lat_ff;
               lon_out_in   = lon_ff;
               stat_out_in  = status_ff;
               if (h_mm > 64'sh0000000FFFFFFFFF) hgt_out_in = 37'sh0FFFFFFFFF;
               else if (h_mm < -64'sh0000001000000000) hgt_out_in = 37'sh1000000000;
               else hgt_out_in = h_mm[36:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // one unit operation in flight at a time
      if (cor_cmd.start || mul_cmd.start || fit_cmd.start) pend_in = 1'b1;
      else if (cor_done || mul_done || fit_done) pend_in = 1'b0;
      else pend_in = pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      ang_ff      <= ang_in;
      rho_ff      <= rho_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      s_ff        <= s_in;
      n_ff        <= n_in;
      t_ff        <= t_in;
      h_ff        <= h_in;
      lat_ff      <= lat_in;
      lon_ff      <= lon_in;
      count_ff    <= count_in;
      status_ff   <= status_in;
      lat_out_ff  <= lat_out_in;
      lon_out_ff  <= lon_out_in;
      hgt_out_ff  <= hgt_out_in;
      stat_out_ff <= stat_out_in;
   end

   // ---------------------------------------------------------------- channels
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.latitude  = lat_out_ff;
   assign rsp_chan.longitude = lon_out_ff;
   assign rsp_chan.height_mm = hgt_out_ff;
   assign rsp_chan.status    = stat_out_ff;

endmodule

// File: tb/ecg_geo_checker.sv
`timescale 1ns / 1ps

module ecg_geo_checker import ecg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ecg_req_if                    req,
   ecg_rsp_if                    rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int FB = FRAC_BITS;
   localparam int GUARD = LEN_GUARD;

   typedef struct packed {
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      logic signed [36:0] height;
      logic [1:0]         status;
   } geo_fix_type;

   geo_fix_type        fix_queue[$];
   logic signed [63:0] arctan_tab [FB];
   logic signed [63:0] gain_recip;
   logic [32:0]        axis_a;
   logic [36:0]        ecc_sq;
   logic [6:0]         iter_max;

   function automatic logic signed [63:0] mul_trunc(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input int s);
      logic        neg;
      logic [63:0] ua;
      logic [63:0] ub;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 64'd0 - a : a;
      ub = b < 0 ? 64'd0 - b : b;
      p = ({64'd0, ua} * {64'd0, ub}) >> s;
      if (p > 128'h7FFFFFFFFFFFFFFF) p = 128'h7FFFFFFFFFFFFFFF;
      return neg ? -signed'(p[63:0]) : signed'(p[63:0]);
   endfunction

   // largest t below 2^62 with t*d (or t*t) not above n
   function automatic logic [63:0] largest_fit(input logic [127:0] n, input logic [63:0] d,
                                               input logic sq);
      logic [63:0]  q;
      logic [63:0]  t;
      logic [127:0] p;
      q = '0;
      for (int b = 61; b >= 0; b--) begin
         t = q | (64'd1 << b);
         p = {64'd0, t} * {64'd0, (sq ? t : d)};
         if (p <= n) q = t;
      end
      return q;
   endfunction

   function automatic logic signed [63:0] frac_div(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
      if (d <= 0 || n < 0) return QCAP;
      return signed'(largest_fit({64'd0, n} << FB, d, 1'b0));
   endfunction

   function automatic logic signed [63:0] frac_sqrt(input logic signed [63:0] w);
      if (w <= 0) return '0;
      return signed'(largest_fit({64'd0, w} << FB, 64'd0, 1'b1));
   endfunction

   function automatic logic signed [63:0] vector_mag(input logic signed [63:0] xi,
                                                     input logic signed [63:0] yi,
                                                     inout logic signed [63:0] ang);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      x = xi;
      y = yi;
      for (int i = 0; i < FB; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x -= ys; y += xs; ang -= arctan_tab[i];
         end else begin
            x += ys; y -= xs; ang += arctan_tab[i];
         end
      end
      return x;
   endfunction

   function automatic void rotate_unit(input logic signed [63:0] th_in,
                                       output logic signed [63:0] c,
                                       output logic signed [63:0] s);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic signed [63:0] th;
      x = gain_recip;
      y = '0;
      th = th_in;
      for (int i = 0; i < FB; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (th >= 0) begin
            x -= ys; y += xs; th -= arctan_tab[i];
         end else begin
            x += ys; y -= xs; th += arctan_tab[i];
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic geo_fix_type geodetic_of(input logic signed [36:0] px,
                                               input logic signed [36:0] py,
                                               input logic signed [36:0] pz);
      logic signed [63:0] one, x, y, z, al, e2q, lat, lon, h, hm;
      logic signed [63:0] ang, rho, b0, b1, n, c, s, d;
      logic [1:0]         st;
      int                 count;
      geo_fix_type        r;
      one = 64'sd1 << FB;
      x = 64'(px) <<< GUARD;
      y = 64'(py) <<< GUARD;
      z = 64'(pz) <<< GUARD;
      al = signed'(64'(axis_a)) <<< GUARD;
      e2q = signed'(64'(ecc_sq) << (FB - 40));
      lon = '0;
      if (x == 0 && y == 0) begin
         // pole: latitude straight up or down, height from the polar radius
         lat = z > 0 ? 64'sd1 << 30 : -(64'sd1 << 30);
         h = (z < 0 ? -z : z) - mul_trunc(al, frac_sqrt(one - e2q), FB);
         st = STAT_POLE;
      end else begin
         ang = '0;
         b0 = '0;
         count = 0;
         if (x < 0) begin
            ang = signed'(PI_Q60 >> (60 - FB));
            if (y < 0) ang = -ang;
            x = -x;
            y = -y;
         end
         rho = mul_trunc(vector_mag(x, y, ang), gain_recip, FB);
         lon = mul_trunc(ang, TWO_OVER_PI_Q63, FB + 33);
         void'(vector_mag(rho, z, b0));
         st = STAT_OK;
         forever begin
            rotate_unit(b0, c, s);
            n = frac_div(al, frac_sqrt(one - mul_trunc(e2q, mul_trunc(s, s, FB), FB)));
            b1 = '0;
            void'(vector_mag(rho, z + mul_trunc(mul_trunc(e2q, n, FB), s, FB), b1));
            d = b1 - b0;
            if (d < 0) d = -d;
            if (d < CONV_THR) break;
            b0 = b1;
            count++;
            if (count > iter_max) begin
               st = STAT_LIMIT;
               break;
            end
         end
         rotate_unit(b1, c, s);
         if (c < 1) c = 64'sd1;   // flat cosine saturates the height
         h = frac_div(rho, c) - n;
         lat = mul_trunc(b1, TWO_OVER_PI_Q63, FB + 33);
      end
      hm = (h + (64'sd1 << (GUARD - 1))) >>> GUARD;
      if (hm > (64'sd1 << 36) - 1) hm = (64'sd1 << 36) - 1;
      if (hm < -(64'sd1 << 36)) hm = -(64'sd1 << 36);
      r.lat = lat[31:0];
      r.lon = lon[31:0];
      r.height = hm[36:0];
      r.status = st;
      return r;
   endfunction

   initial begin
      logic [63:0]        sum;
      logic signed [63:0] dummy;
      int                 e;
      arctan_tab[0] = signed'(PI_Q60 >> (62 - FB));
      for (int i = 1; i < FB; i++) begin
         sum = '0;
         for (int k = 0; k < 63; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
               if (k % 2) sum -= (64'd1 << e) / (2 * k + 1);
               else sum += (64'd1 << e) / (2 * k + 1);
            end
         end
         arctan_tab[i] = signed'((sum + (64'd1 << (61 - FB))) >> (62 - FB));
      end
      dummy = '0;
      gain_recip = '0;
      gain_recip = frac_div(64'sd1 << FB, vector_mag(64'sd1 << FB, 64'sd0, dummy));
   end

   assign pending = fix_queue.size();

   always @(posedge clock) begin
      geo_fix_type want;
      if (reset) begin
         axis_a <= 33'd6378137000;
         ecc_sq <= 37'd7360548600;
         iter_max <= 7'd100;
         fix_queue.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               CSR_SEMI_MAJOR: axis_a <= pwdata[32:0];
               CSR_ECC_SQ:     ecc_sq <= pwdata[36:0];
               CSR_ITER_LIMIT: iter_max <= pwdata[6:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            fix_queue.push_back(geodetic_of(req.pos_x_mm, req.pos_y_mm, req.pos_z_mm));
         if (rsp.valid && rsp.ready) begin
            if (fix_queue.size() == 0) begin
               $error("result word with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = fix_queue.pop_front();
               if (rsp.latitude !== want.lat || rsp.longitude !== want.lon ||
                   rsp.height_mm !== want.height || rsp.status !== want.status) begin
                  fail_count <= fail_count + 1;
                  if (rsp.latitude !== want.lat)
                     $error("latitude expected %0d got %0d", want.lat, rsp.latitude);
                  if (rsp.longitude !== want.lon)
                     $error("longitude expected %0d got %0d", want.lon, rsp.longitude);
                  if (rsp.height_mm !== want.height)
                     $error("height_mm expected %0d got %0d", want.height, rsp.height_mm);
                  if (rsp.status !== want.status)
                     $error("status expected %0d got %0d", want.status, rsp.status);
               end
            end
         end
      end
   end

endmodule

// File: tb/ecef_to_geodetic_test.sv
`timescale 1ns / 1ps

module ecef_to_geodetic_test import ecg_pkg::*;;

   localparam longint CYCLE_LIMIT = 80000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [63:0]           pwdata = '0;
   logic [63:0]           prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending;
   longint                cycles = 0;
   int                    words_in = 0;
   logic                  calm = 1'b0;   // no idling in the closing phase

   ecg_req_if req_chan();
   ecg_rsp_if rsp_chan();

   ecef_to_geodetic uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ecg_geo_checker geo_check (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off once 30 words have been sent
   initial begin
      int hold;
      bit held;
      held = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && words_in >= 30) begin
            held = 1;
            rsp_chan.ready = 1'b0;
            hold = 0;
            // long enough for two slow words to fill the block and refuse input words
            while (hold < 80000) begin
               @(negedge clock);
               hold++;
            end
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // setup then access cycle; the register takes the word at the access edge
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = CSR_ADDR_W'(idx) << 3;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // wait until every predicted fix has come back
   task automatic drain();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic send_pos(input logic signed [36:0] x, input logic signed [36:0] y,
                           input logic signed [36:0] z);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.pos_x_mm = x;
      req_chan.pos_y_mm = y;
      req_chan.pos_z_mm = z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_in++;
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   function automatic logic signed [36:0] any_coord();
      logic signed [36:0] v;
      v = 37'({$urandom, $urandom});
      return v >>> $urandom_range(0, 36);
   endfunction

   // roughly earth sized, up to about 8600 km per axis
   function automatic logic signed [36:0] near_coord();
      logic signed [33:0] v;
      v = 34'({$urandom, $urandom});
      return 37'(v);
   endfunction

   task automatic random_positions(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) send_pos(near_coord(), near_coord(), near_coord());
         else if (pick < 85) send_pos(any_coord(), any_coord(), any_coord());
         else if (pick < 95) send_pos(37'sd0, 37'sd0, any_coord());
         else if (pick < 98) send_pos(37'sd0, near_coord(), near_coord());
         else send_pos(near_coord(), 37'sd0, near_coord());
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pos_x_mm = '0;
      req_chan.pos_y_mm = '0;
      req_chan.pos_z_mm = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: poles, axis points, quadrants and extremes at reset values
      send_pos(37'sd0, 37'sd0, 37'sd6356752314);
      send_pos(37'sd0, 37'sd0, -37'sd6356752314);
      send_pos(37'sd0, 37'sd0, 37'sd0);
      send_pos(37'sd0, 37'sd0, 37'sh0FFFFFFFFF);
      send_pos(37'sd0, 37'sd0, -37'sh1000000000);
      send_pos(37'sd6378137000, 37'sd0, 37'sd0);
      send_pos(-37'sd6378137000, 37'sd0, 37'sd0);
      send_pos(37'sd0, 37'sd6378137000, 37'sd0);
      send_pos(37'sd0, -37'sd6378137000, 37'sd0);
      send_pos(-37'sd4000000000, -37'sd3000000000, 37'sd3500000000);
      send_pos(-37'sd4000000000, 37'sd3000000000, -37'sd3500000000);
      send_pos(37'sd4510731000, 37'sd4510731000, 37'sd1000);
      send_pos(37'sd1, 37'sd0, 37'sd0);
      send_pos(-37'sd1, -37'sd1, 37'sd1);
      send_pos(37'sd1, 37'sd1, -37'sh1000000000);
      send_pos(37'sh0FFFFFFFFF, 37'sh0FFFFFFFFF, 37'sh0FFFFFFFFF);
      send_pos(-37'sh1000000000, -37'sh1000000000, -37'sh1000000000);
      send_pos(-37'sh1000000000, 37'sh0FFFFFFFFF, 37'sd0);
      send_pos(37'sd10, 37'sd10, 37'sd6356000000);
      send_pos(37'sd1000000, 37'sd0, 37'sd6356000000);
      random_positions(220);
      drain();

      // near-default ellipsoid, short limit
      csr_write(CSR_SEMI_MAJOR, 64'd6378136000);
      csr_write(CSR_ECC_SQ, 64'd7360556000);
      csr_write(CSR_ITER_LIMIT, 64'd3);
      random_positions(130);
      drain();

      // smallest axis, sphere, one refinement
      csr_write(CSR_SEMI_MAJOR, 64'd6000000000);
      csr_write(CSR_ECC_SQ, 64'd0);
      csr_write(CSR_ITER_LIMIT, 64'd1);
      random_positions(130);
      drain();

      // largest axis and eccentricity in range, full limit
      csr_write(CSR_SEMI_MAJOR, 64'd7000000000);
      csr_write(CSR_ECC_SQ, 64'd109951162777);
      csr_write(CSR_ITER_LIMIT, 64'd100);
      random_positions(130);
      drain();

      // register field maxima, limit of zero
      csr_write(CSR_SEMI_MAJOR, 64'h1FFFFFFFF);
      csr_write(CSR_ECC_SQ, 64'h1FFFFFFFFF);
      csr_write(CSR_ITER_LIMIT, 64'd0);
      random_positions(130);
      drain();

      // back to the defaults, widest limit, then a calm finish
      csr_write(CSR_SEMI_MAJOR, 64'd6378137000);
      csr_write(CSR_ECC_SQ, 64'd7360548600);
      csr_write(CSR_ITER_LIMIT, 64'd127);
      random_positions(70);
      calm = 1'b1;
      random_positions(70);
      drain();

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: ecef_to_geodetic.f
sv/ecg_pkg.sv
sv/ecg_req_if.sv
sv/ecg_rsp_if.sv
sv/ecg_cordic.sv
sv/ecg_mul.sv
sv/ecg_fit.sv
sv/ecef_to_geodetic.sv
tb/ecg_geo_checker.sv
tb/ecef_to_geodetic_test.sv
